/* design/bgd_pkg.sv */
// Shared types and constants for the button gesture detector.
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_W          = 16;

  localparam logic             PRESS_LOW_RST  = 1'b1;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST       = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd300;

  typedef enum logic [1:0] {
    CFG_PRESS_LOW  = 2'd0,
    CFG_DEBOUNCE   = 2'd1,
    CFG_LONG       = 2'd2,
    CFG_DOUBLE_GAP = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    G_SHORT   = 2'd0,
    G_LONG    = 2'd1,
    G_DOUBLE  = 2'd2,
    G_RELEASE = 2'd3
  } gesture_t;

  // Timer verdicts for the tick being processed.
  typedef struct packed {
    logic edge_ok;   // accepted edge after debounce
    logic pressed;   // the accepted edge is a press
    logic long_due;  // counter has reached the long press time
    logic gap_due;   // counter has reached the double press gap
  } tick_info_t;

  typedef struct packed {
    logic     valid;
    gesture_t code;
  } gesture_res_t;

endpackage

/* design/bgd_timer.sv */
// Elapsed counter, edge detection, debounce and timeout compares.
`timescale 1ns / 1ps

module bgd_timer import bgd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             pin_level,
  input  logic             press_low,
  input  logic [CFG_W-1:0] settle_ticks,
  input  logic [CFG_W-1:0] long_ms,
  input  logic [CFG_W-1:0] gap_ticks,
  output tick_info_t       info
);

  localparam int W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                  prev_level_r;
  logic                  saturated;
  logic                  level_edge;
  logic                  deb_ok;

  // Compare against a threshold clamped to the counter range. A threshold
  // beyond the range behaves as the maximum, reached only when saturated.
  function automatic logic reached(input logic [TIMER_BITS-1:0] cnt,
                                   input logic [CFG_W-1:0] thr);
    logic [W-1:0] cnt_ext, thr_ext, max_ext;
    cnt_ext = W'(cnt);
    thr_ext = W'(thr);
    max_ext = W'(CNT_MAX);
    return (thr_ext > max_ext) ? (cnt == CNT_MAX) : (cnt_ext >= thr_ext);
  endfunction

  always_comb begin
    saturated   = (elapsed_r == CNT_MAX);
    elapsed_inc = saturated ? elapsed_r : elapsed_r + 1'b1;
    level_edge  = (pin_level != prev_level_r);
    deb_ok      = reached(elapsed_inc, settle_ticks);

    info.edge_ok  = level_edge && deb_ok;
    info.pressed  = ((pin_level == 1'b0) == press_low);
    info.long_due = reached(elapsed_inc, long_ms);
    info.gap_due  = reached(elapsed_inc, gap_ticks);

    elapsed_nxt = info.edge_ok ? '0 : elapsed_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r    <= '0;
      prev_level_r <= 1'b1;
    end else if (advance) begin
      elapsed_r    <= elapsed_nxt;
      prev_level_r <= pin_level;
    end
  end

endmodule

/* design/bgd_fsm.sv */
// Gesture state machine: turns accepted edges and timeouts into gestures.
`timescale 1ns / 1ps

module bgd_fsm import bgd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  tick_info_t   info,
  output gesture_res_t res
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DOWN     = 5'b00010,
    ST_WAIT_2ND = 5'b00100,
    ST_HELD     = 5'b01000,
    ST_DONE     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    res.valid = 1'b0;
    res.code  = G_SHORT;
    if (info.edge_ok) begin
      case (state_r)
        ST_DOWN: begin
          if (!info.pressed) state_nxt = ST_WAIT_2ND;
        end
        ST_WAIT_2ND: begin
          if (info.pressed) begin
            state_nxt = ST_DONE;
            res.valid = 1'b1;
            res.code  = G_DOUBLE;
          end
        end
        ST_HELD: begin
          if (!info.pressed) begin
            state_nxt = ST_IDLE;
            res.valid = 1'b1;
            res.code  = G_RELEASE;
          end
        end
        ST_DONE: begin
          if (!info.pressed) state_nxt = ST_IDLE;
        end
        default: begin
          // Idle, and any unreachable code, which behaves as idle.
          state_nxt = info.pressed ? ST_DOWN : ST_IDLE;
        end
      endcase
    end else begin
      case (state_r)
        ST_DOWN: begin
          if (info.long_due) begin
            state_nxt = ST_HELD;
            res.valid = 1'b1;
            res.code  = G_LONG;
          end
        end
        ST_WAIT_2ND: begin
          if (info.gap_due) begin
            state_nxt = ST_IDLE;
            res.valid = 1'b1;
            res.code  = G_SHORT;
          end
        end
        ST_HELD, ST_DONE: state_nxt = state_r;
        default:          state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/button_gesture_detector_top.sv */
// Top level of the button gesture detector: ports, item and result registers.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------
//  in_     | input     | in_valid / in_stall    | in_pin_level (1 bit, one tick)
//  out_    | output    | out_valid / out_stall  | out_gesture_code (2 bits)
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index (2), cfg_data (16)
//
// Each beat on the input is one millisecond tick. It is captured in an item
// register; once the result register is free or draining, the timer and state
// machine process it in a single pass and load the result register; one tick
// per cycle is sustained while the output does not stall.
// Reset (rst_n low, synchronous) restores the registers to their defaults,
// the state machine to idle, the counter to zero and the last level to one.
// A stalled result holds the item register, which then stalls the input;
// ticks that produce no gesture are held too, so order is always kept.
// Configuration writes are always ready and must only occur while idle.

module button_gesture_detector_top import bgd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_pin_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_gesture_code,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration registers.
  logic             press_low_r;
  logic [CFG_W-1:0] debounce_r, long_r, double_gap_r;

  // Item register holding the tick under processing.
  logic s1_valid_r;
  logic s1_pin_r;

  // Result register.
  logic     out_valid_r;
  gesture_t out_code_r;

  logic         fire;
  tick_info_t   info;
  gesture_res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_low_r  <= PRESS_LOW_RST;
      debounce_r   <= DEBOUNCE_RST;
      long_r       <= LONG_RST;
      double_gap_r <= DOUBLE_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRESS_LOW:  press_low_r  <= cfg_data[0];
        CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        CFG_LONG:       long_r       <= cfg_data;
        CFG_DOUBLE_GAP: double_gap_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // The held tick is processed when the result register is free or is being
  // drained this cycle.
  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pin_r <= in_pin_level;
    end
  end

  bgd_timer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_timer (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (fire),
    .pin_level    (s1_pin_r),
    .press_low    (press_low_r),
    .settle_ticks (debounce_r),
    .long_ms      (long_r),
    .gap_ticks    (double_gap_r),
    .info         (info)
  );

  bgd_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (fire),
    .info    (info),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_code_r <= res.code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gesture_code = out_code_r;

  // The input is only held back when a tick is waiting in the item register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with no tick held");

  // A held tick never overtakes a result that is still stalled.
  a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s1_valid_r) |-> in_stall)
    else $error("tick processed while a result was stalled");

  // A gesture produced by a processed tick shows up as a result beat.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid) |=> out_valid_r)
    else $error("gesture lost on its way to the result register");

endmodule

/* tb/button_gesture_detector_top_tb.sv */
// Self-checking testbench for the button gesture detector: scoreboard class and top module.
`timescale 1ns / 1ps

// Gesture machine states, kept apart from the RTL encoding.
typedef enum logic [2:0] {
  ST_IDLE,
  ST_DOWN,
  ST_WAIT_SECOND,
  ST_HELD,
  ST_DONE
} press_state_t;

// Tracks the button timing state, predicts the gestures and checks them in order.
class gesture_scoreboard;
  logic                                press_low;
  logic [bgd_pkg::CFG_W-1:0]           settle_ticks;
  logic [bgd_pkg::CFG_W-1:0]           long_ms;
  logic [bgd_pkg::CFG_W-1:0]           gap_ticks;
  press_state_t                        state;
  logic [bgd_pkg::TIMER_BITS_DEF-1:0]  elapsed;
  logic                                last_level;
  bgd_pkg::gesture_t                   gestures_due[$];
  int                                  errors;

  function new();
    press_low    = bgd_pkg::PRESS_LOW_RST;
    settle_ticks = bgd_pkg::DEBOUNCE_RST;
    long_ms      = bgd_pkg::LONG_RST;
    gap_ticks    = bgd_pkg::DOUBLE_GAP_RST;
    state        = ST_IDLE;
    elapsed      = '0;
    last_level   = 1'b1;
    errors       = 0;
  endfunction

  function void set_reg(bgd_pkg::cfg_idx_t idx, logic [bgd_pkg::CFG_W-1:0] data);
    case (idx)
      bgd_pkg::CFG_PRESS_LOW:  press_low    = data[0];
      bgd_pkg::CFG_DEBOUNCE:   settle_ticks = data;
      bgd_pkg::CFG_LONG:       long_ms      = data;
      bgd_pkg::CFG_DOUBLE_GAP: gap_ticks    = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return gestures_due.size();
  endfunction

  // A threshold wider than the counter behaves as the counter's maximum.
  function bit reached(logic [bgd_pkg::CFG_W-1:0] limit);
    return (elapsed >= limit) || (elapsed == '1);
  endfunction

  function void note_tick(logic level);
    logic edge_seen;
    logic is_press;
    edge_seen  = (level != last_level);
    last_level = level;
    if (elapsed != '1) elapsed++;
    if (edge_seen && reached(settle_ticks)) begin
      is_press = ((level == 1'b0) == press_low);
      elapsed  = '0;
      case (state)
        ST_IDLE:        if (is_press) state = ST_DOWN;
        ST_DOWN:        if (!is_press) state = ST_WAIT_SECOND;
        ST_WAIT_SECOND: if (is_press) begin
          gestures_due.push_back(bgd_pkg::G_DOUBLE);
          state = ST_DONE;
        end
        ST_HELD:        if (!is_press) begin
          gestures_due.push_back(bgd_pkg::G_RELEASE);
          state = ST_IDLE;
        end
        default:        if (!is_press) state = ST_IDLE;
      endcase
    end else if (state == ST_DOWN) begin
      if (reached(long_ms)) begin
        gestures_due.push_back(bgd_pkg::G_LONG);
        state = ST_HELD;
      end
    end else if (state == ST_WAIT_SECOND) begin
      if (reached(gap_ticks)) begin
        gestures_due.push_back(bgd_pkg::G_SHORT);
        state = ST_IDLE;
      end
    end
  endfunction

  task report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  task check_gesture(logic [1:0] code);
    bgd_pkg::gesture_t want;
    if (gestures_due.size() == 0) begin
      report_mismatch($sformatf("gesture %0d arrived with none due", code));
    end else begin
      want = gestures_due.pop_front();
      if (code !== want)
        report_mismatch($sformatf("gesture %0d, expected %0d", code, want));
    end
  endtask
endclass

module button_gesture_detector_top_tb;
  import bgd_pkg::*;

  // Cycles without any beat on any channel before the run is declared hung.
  // The heaviest stall rate is 86 percent, so a quiet stretch this long
  // cannot happen in a correct run.
  localparam int IDLE_LIMIT = 4000;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_pin_level = 1'b1;
  logic             out_stall    = 1'b0;
  logic             cfg_valid    = 1'b0;
  logic [1:0]       cfg_index    = CFG_PRESS_LOW;
  logic [CFG_W-1:0] cfg_data     = '0;
  wire              in_stall;
  wire              out_valid;
  wire              cfg_ready;
  wire  [1:0]       out_gesture_code;

  // Idle rates in percent for the sender and the receiver.
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  // Pin level of the most recent tick that went in.
  logic level_now = 1'b1;

  gesture_scoreboard sb = new();

  button_gesture_detector_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_gesture_code (out_gesture_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random, drawn fresh every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Beat monitor. The result is checked before the tick of the same edge is
  // noted; they never belong together, since a tick must pass the item register first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_gesture(out_gesture_code);
      if (in_valid && !in_stall) sb.note_tick(in_pin_level);
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("button_gesture_detector_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one tick, possibly after a few idle cycles, and returns once the
  // beat has been taken. Valid stays high into the next tick, so there is
  // only ever one assignment to it per edge.
  task automatic send_tick(input logic level);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= level;
    do @(posedge clk); while (in_stall !== 1'b0);
    level_now = level;
  endtask

  task automatic hold(input logic level, input int count);
    repeat (count) send_tick(level);
  endtask

  // Stops sending and waits until every predicted gesture has come back.
  // The extra cycles cover ticks still in flight that produce no gesture.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic configure(input logic al, input logic [CFG_W-1:0] deb,
                           input logic [CFG_W-1:0] lng, input logic [CFG_W-1:0] gap);
    drain();
    write_reg(CFG_PRESS_LOW, {{(CFG_W-1){1'b0}}, al});
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG, lng);
    write_reg(CFG_DOUBLE_GAP, gap);
    cfg_valid <= 1'b0;
  endtask

  // Hand-built gestures for a debounce of 2, a long time of 4 and a gap of 3:
  // a short press, a long press with its release, a double press with the
  // release that ends it, and finally a bounce that arrives too soon.
  task automatic directed_gestures();
    logic rel;
    logic prs;
    rel = sb.press_low;
    prs = ~rel;
    hold(rel, 5);
    hold(prs, 2);
    hold(rel, 5);
    hold(prs, 6);
    hold(rel, 2);
    hold(prs, 2);
    hold(rel, 2);
    hold(prs, 2);
    hold(rel, 3);
    hold(prs, 1);
    hold(rel, 1);
  endtask

  // Random runs of alternating level. Run lengths cluster around the
  // debounce, long press and double gap times so that gestures land on both
  // sides of every threshold; the rest are free lengths.
  task automatic random_ticks(input int count);
    int   sent;
    int   len;
    logic level;
    sent  = 0;
    level = level_now;
    while (sent < count) begin
      level = ~level;
      case ($urandom_range(0, 4))
        0:       len = $urandom_range(1, int'(sb.settle_ticks) + 1);
        1:       len = int'(sb.long_ms) - 1 + int'($urandom_range(0, 2));
        2:       len = int'(sb.gap_ticks) - 1 + int'($urandom_range(0, 2));
        default: len = $urandom_range(1, 2 * int'(sb.long_ms));
      endcase
      if (len < 1) len = 1;
      if (len > count - sent) len = count - sent;
      hold(level, len);
      sent += len;
      // Now and then the sender waits for every gesture to come back.
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  task automatic random_setting();
    configure(1'($urandom_range(0, 1)), 16'($urandom_range(0, 4)),
              16'($urandom_range(1, 24)), 16'($urandom_range(1, 16)));
    random_ticks(60);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Light sender gaps, heavy receiver stalls.
    send_gap_pct = 28;
    stall_pct    = 86;

    // Reset settings: one short press, active low, 50 ms debounce, 300 ms gap.
    hold(1'b1, 55);
    hold(1'b0, 55);
    hold(1'b1, 302);

    configure(1'b1, 16'd2, 16'd4, 16'd3);
    directed_gestures();
    random_setting();
    random_setting();

    // Heavy sender gaps, light receiver stalls; active high pin this time.
    send_gap_pct = 86;
    stall_pct    = 28;
    configure(1'b0, 16'd2, 16'd4, 16'd3);
    directed_gestures();
    random_setting();
    random_setting();

    // No idling at all from here on.
    send_gap_pct = 0;
    stall_pct    = 0;

    // Smallest thresholds: every edge is taken and timeouts fire after one tick.
    configure(1'b1, 16'd0, 16'd1, 16'd1);
    random_ticks(40);
    random_setting();

    // Largest thresholds: the counter stays far below them in this stretch,
    // so every edge is ignored and no timeout fires.
    configure(1'($urandom_range(0, 1)), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_ticks(40);

    drain();
    if (sb.errors == 0) begin
      $display("button_gesture_detector_top: match");
    end else begin
      $display("button_gesture_detector_top: mismatch");
    end
    $finish;
  end
endmodule
